/* hw/rtl/sic_pkg.sv */
// Shared types and constants of the segment intersection classifier.
// No dependencies; every module of the block imports this package.
`default_nettype none

package sic_pkg;

    // Width of the touch tolerance register.
    localparam int TOL_BITS = 50;

    // Number of coordinate differences formed in the first stage.
    localparam int NUM_DIFFS = 12;

    // Result codes of one classification.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_CROSS = 2'd2
    } t_kind;

    // Control that travels with the differences.
    typedef struct packed {
        logic valid;
        logic exact;
    } t_ctl_diff;

    // Control that travels with the products and the areas.
    // Bit order of span: B start on A, B end on A, A start on B, A end on B.
    typedef struct packed {
        logic       valid;
        logic       exact;
        logic [3:0] span;
    } t_ctl_span;

endpackage

`default_nettype wire

/* hw/rtl/segment_intersection_classify.sv */
// Top level of the segment intersection classifier: tolerance register and
// the four-stage pipeline. Depends on sic_pkg, sic_diff, sic_mult, sic_area
// and sic_classify.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   It carries the endpoints of segments A and B and the exact_mode flag.
//   After the difference, product, area and result registers, o_done is high
//   for one cycle with o_crossing_kind: none, endpoint touch or proper crossing.
//   A new pair may be started in every cycle in which busy is low, so
//   throughput is one pair per cycle. The four stages are differences,
//   multipliers with span tests, area subtraction, and tolerance compare
//   with classification; the multiplier stage sets the clock.
//   The touch tolerance is written with i_cfg_we and i_cfg_wdata while no
//   transaction is in flight; it resets to zero.
//   Reset is synchronous and active low. It clears all valid bits and sets
//   busy, which stays high until the first clock edge with reset released.
//   The receiver cannot stall: every result is shown for one cycle only.
`default_nettype none

module segment_intersection_classify #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_y,
    input  wire logic                         i_exact_mode,
    input  wire logic                         i_cfg_we,
    input  wire logic [sic_pkg::TOL_BITS-1:0] i_cfg_wdata,
    output logic                              o_done,
    output logic [1:0]                        o_crossing_kind
);
    import sic_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic                r_busy;
    logic [TOL_BITS-1:0] r_tol;
    logic                accept;

    t_ctl_diff            ctl_diff;
    logic signed [DW-1:0] diff [NUM_DIFFS];
    t_ctl_span            ctl_prod;
    logic signed [PW-1:0] prod [8];
    t_ctl_span            ctl_area;
    logic signed [PW-1:0] area [4];
    t_kind                kind;

    // Busy holds off transactions during reset and until the first clock edge with reset released.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // Touch tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    sic_diff #(
        .COORD_BITS (COORD_BITS)
    ) u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_exact     (i_exact_mode),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_ctl       (ctl_diff),
        .o_diff      (diff)
    );

    sic_mult #(
        .COORD_BITS (COORD_BITS)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_diff),
        .i_diff  (diff),
        .o_ctl   (ctl_prod),
        .o_prod  (prod)
    );

    sic_area #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_prod),
        .i_prod  (prod),
        .o_ctl   (ctl_area),
        .o_area  (area)
    );

    sic_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_tol),
        .i_ctl   (ctl_area),
        .i_area  (area),
        .o_done  (o_done),
        .o_kind  (kind)
    );

    assign o_crossing_kind = kind;

`ifndef SYNTHESIS
    // Every accepted transaction produces a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_done)
        else $error("accepted transaction gave no result after four cycles");

    // No result appears without a matching accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 4))
        else $error("result strobe without a matching transaction");

    // A result never carries the unused code.
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_crossing_kind != 2'd3))
        else $error("result carries an undefined crossing kind");

    // Busy is raised by reset.
    a_busy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy not raised after reset");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sic_diff.sv */
// First pipeline stage: coordinate differences of the segment pair.
// Depends on sic_pkg for the difference count and the control struct.
`default_nettype none

module sic_diff #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_exact,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_y,
    output sic_pkg::t_ctl_diff                o_ctl,
    output logic signed [COORD_BITS:0]        o_diff [sic_pkg::NUM_DIFFS]
);
    import sic_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] n_diff [NUM_DIFFS];
    logic signed [DW-1:0] r_diff [NUM_DIFFS];
    t_ctl_diff            r_ctl;

    // Sign-extended difference of two coordinates, one bit wider.
    function automatic logic signed [DW-1:0] sub_ext(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [DW-1:0] ea;
        logic [DW-1:0] eb;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        return $signed(ea - eb);
    endfunction

    // Segment A direction and the B endpoints relative to the A start.
    // Then segment B direction and the A endpoints relative to the B start.
    always_comb begin
        n_diff[0]  = sub_ext(i_a_end_x,   i_a_start_x);
        n_diff[1]  = sub_ext(i_a_end_y,   i_a_start_y);
        n_diff[2]  = sub_ext(i_b_start_x, i_a_start_x);
        n_diff[3]  = sub_ext(i_b_start_y, i_a_start_y);
        n_diff[4]  = sub_ext(i_b_end_x,   i_a_start_x);
        n_diff[5]  = sub_ext(i_b_end_y,   i_a_start_y);
        n_diff[6]  = sub_ext(i_b_end_x,   i_b_start_x);
        n_diff[7]  = sub_ext(i_b_end_y,   i_b_start_y);
        n_diff[8]  = sub_ext(i_a_start_x, i_b_start_x);
        n_diff[9]  = sub_ext(i_a_start_y, i_b_start_y);
        n_diff[10] = sub_ext(i_a_end_x,   i_b_start_x);
        n_diff[11] = sub_ext(i_a_end_y,   i_b_start_y);
    end

    // Valid bit with reset; the payload registers load every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_valid;
        end
        r_ctl.exact <= i_exact;
        r_diff      <= n_diff;
    end

    assign o_ctl  = r_ctl;
    assign o_diff = r_diff;

endmodule

`default_nettype wire

/* hw/rtl/sic_mult.sv */
// Second pipeline stage: the eight cross-product terms and the span tests.
// Depends on sic_pkg for the control structs and the difference count.
`default_nettype none

module sic_mult #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sic_pkg::t_ctl_diff              i_ctl,
    input  wire logic signed [COORD_BITS:0]      i_diff [sic_pkg::NUM_DIFFS],
    output sic_pkg::t_ctl_span                   o_ctl,
    output logic signed [2*COORD_BITS+1:0]       o_prod [8]
);
    import sic_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [PW-1:0] n_prod [8];
    logic signed [PW-1:0] r_prod [8];
    logic [3:0]           n_span;
    t_ctl_span            r_ctl;

    // Magnitude of a difference; it always fits the same width unsigned.
    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // Point inside the span of a segment along its longer axis.
    // dx, dy: segment direction; rx, ry: point relative to the segment start.
    // Equal extents pick the x axis.
    function automatic logic span_test(
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy,
        input logic signed [DW-1:0] rx,
        input logic signed [DW-1:0] ry
    );
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] r;
        if (mag(dx) >= mag(dy)) begin
            d = dx;
            r = rx;
        end else begin
            d = dy;
            r = ry;
        end
        return ((r >= 0) && (r <= d)) || ((r <= 0) && (r >= d));
    endfunction

    // Cross-product terms: even entries are dir_x * rel_y, odd dir_y * rel_x.
    always_comb begin
        n_prod[0] = PW'(i_diff[0]) * PW'(i_diff[3]);
        n_prod[1] = PW'(i_diff[1]) * PW'(i_diff[2]);
        n_prod[2] = PW'(i_diff[0]) * PW'(i_diff[5]);
        n_prod[3] = PW'(i_diff[1]) * PW'(i_diff[4]);
        n_prod[4] = PW'(i_diff[6]) * PW'(i_diff[9]);
        n_prod[5] = PW'(i_diff[7]) * PW'(i_diff[8]);
        n_prod[6] = PW'(i_diff[6]) * PW'(i_diff[11]);
        n_prod[7] = PW'(i_diff[7]) * PW'(i_diff[10]);
    end

    // Span tests of the four endpoints against the other segment.
    always_comb begin
        n_span[0] = span_test(i_diff[0], i_diff[1], i_diff[2],  i_diff[3]);
        n_span[1] = span_test(i_diff[0], i_diff[1], i_diff[4],  i_diff[5]);
        n_span[2] = span_test(i_diff[6], i_diff[7], i_diff[8],  i_diff[9]);
        n_span[3] = span_test(i_diff[6], i_diff[7], i_diff[10], i_diff[11]);
    end

    // Valid bit with reset; the payload registers load every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.exact <= i_ctl.exact;
        r_ctl.span  <= n_span;
        r_prod      <= n_prod;
    end

    assign o_ctl  = r_ctl;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* hw/rtl/sic_area.sv */
// Third pipeline stage: the four doubled signed areas.
// Depends on sic_pkg for the control struct.
`default_nettype none

module sic_area #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sic_pkg::t_ctl_span         i_ctl,
    input  wire logic signed [2*COORD_BITS+1:0] i_prod [8],
    output sic_pkg::t_ctl_span              o_ctl,
    output logic signed [2*COORD_BITS+1:0]  o_area [4]
);
    import sic_pkg::*;

    localparam int AW = 2 * COORD_BITS + 2;

    logic signed [AW-1:0] n_area [4];
    logic signed [AW-1:0] r_area [4];
    t_ctl_span            r_ctl;

    // Each area is the difference of its two terms; it cannot overflow.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_area[k] = i_prod[2*k] - i_prod[2*k+1];
        end
    end

    // Valid bit with reset; the payload registers load every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.exact <= i_ctl.exact;
        r_ctl.span  <= i_ctl.span;
        r_area      <= n_area;
    end

    assign o_ctl  = r_ctl;
    assign o_area = r_area;

endmodule

`default_nettype wire

/* hw/rtl/sic_classify.sv */
// Last pipeline stage: tolerance tests, sign tests and the result register.
// Depends on sic_pkg for the result codes, tolerance width and control struct.
`default_nettype none

module sic_classify #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sic_pkg::TOL_BITS-1:0]   i_tol,
    input  wire sic_pkg::t_ctl_span             i_ctl,
    input  wire logic signed [2*COORD_BITS+1:0] i_area [4],
    output logic                                o_done,
    output sic_pkg::t_kind                      o_kind
);
    import sic_pkg::*;

    localparam int AW = 2 * COORD_BITS + 2;
    localparam int CW = ((AW > TOL_BITS) ? AW : TOL_BITS) + 2;

    logic [TOL_BITS-1:0]  tol;
    logic signed [CW-1:0] tol_pos;
    logic signed [CW-1:0] tol_neg;
    logic signed [CW-1:0] area_ext [4];
    logic [3:0]           near;
    logic [3:0]           neg;
    t_kind                n_kind;
    t_kind                r_kind;
    logic                 r_done;

    // Exact mode compares against zero.
    assign tol     = i_ctl.exact ? '0 : i_tol;
    assign tol_pos = $signed({{(CW-TOL_BITS){1'b0}}, tol});
    assign tol_neg = -tol_pos;

    // Near-zero test: -tol <= area <= tol, in a width that holds both sides.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            area_ext[k] = $signed({{(CW-AW){i_area[k][AW-1]}}, i_area[k]});
            near[k]     = (area_ext[k] <= tol_pos) && (area_ext[k] >= tol_neg);
            neg[k]      = i_area[k][AW-1];
        end
    end

    // A touch wins; otherwise both sign pairs must differ for a crossing.
    always_comb begin
        if ((near & i_ctl.span) != 4'b0000) begin
            n_kind = KIND_TOUCH;
        end else if ((neg[0] != neg[1]) && (neg[2] != neg[3])) begin
            n_kind = KIND_CROSS;
        end else begin
            n_kind = KIND_NONE;
        end
    end

    // Result strobe with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_done = r_done;
    assign o_kind = r_kind;

endmodule

`default_nettype wire
